// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned LEN_W      = 64;
  localparam int unsigned OUT_DATA_W = 88;  // 81 field bits padded to whole bytes

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic             fin;
    logic [2:0]       reserved_bits;
    logic [3:0]       opcode;
    logic             masked;
    logic [LEN_W-1:0] payload_length;
    logic             last;
  } result_t;

endpackage

// ===== rtl/wsd_parser.sv =====
`include "assert_macros.svh"

module wsd_parser
  import wsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [IN_DATA_W-1:0] in_byte,
  output logic                 res_valid,
  output result_t              res
);

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_EXT   = 3'd2;
  localparam logic [2:0] PH_KEY   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  logic [2:0]       phase, phase_next;
  logic [2:0]       cnt, cnt_next;
  logic [7:0]       header_bits, header_bits_next;
  logic             mask_flag, mask_flag_next;
  logic [6:0]       short_length, short_length_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] remaining, remaining_next;  // payload bytes still to come
  logic [1:0]       key_idx, key_idx_next;
  logic [31:0]      key_word, key_word_next;

  logic             finish;
  logic [7:0]       key_byte;
  logic [2:0]       cnt_inc;

  assign cnt_inc = cnt + 3'd1;

  always_comb begin
    unique case (key_idx)
      2'd0: key_byte = key_word[31:24];
      2'd1: key_byte = key_word[23:16];
      2'd2: key_byte = key_word[15:8];
      default: key_byte = key_word[7:0];
    endcase
  end

  always_comb begin
    phase_next        = phase;
    cnt_next          = cnt;
    header_bits_next  = header_bits;
    mask_flag_next    = mask_flag;
    short_length_next = short_length;
    frame_length_next = frame_length;
    remaining_next    = remaining;
    key_idx_next      = key_idx;
    key_word_next     = key_word;
    finish            = 1'b0;
    res_valid         = 1'b0;
    res.kind          = KIND_HEADER;
    res.data_byte     = 8'h00;
    res.last          = 1'b0;

    unique case (phase)
      PH_FIRST: begin
        header_bits_next  = in_byte;
        mask_flag_next    = 1'b0;
        short_length_next = 7'd0;
        frame_length_next = '0;
        key_word_next     = '0;
        cnt_next          = 3'd0;
        phase_next        = PH_LEN;
      end
      PH_LEN: begin
        mask_flag_next    = in_byte[7];
        short_length_next = in_byte[6:0];
        cnt_next          = 3'd0;
        if (in_byte[6:0] == LEN_CODE_16 || in_byte[6:0] == LEN_CODE_64) begin
          frame_length_next = '0;
          phase_next        = PH_EXT;
        end else begin
          frame_length_next = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
          if (in_byte[7]) phase_next = PH_KEY;
          else            finish     = 1'b1;
        end
      end
      PH_EXT: begin
        // big-endian: shift in from the bottom; 8 bytes wrap the count to zero
        frame_length_next = {frame_length[LEN_W-9:0], in_byte};
        cnt_next          = cnt_inc;
        if (cnt_inc == ((short_length == LEN_CODE_16) ? 3'd2 : 3'd0)) begin
          cnt_next = 3'd0;
          if (mask_flag) phase_next = PH_KEY;
          else           finish     = 1'b1;
        end
      end
      PH_KEY: begin
        key_word_next = {key_word[23:0], in_byte};
        cnt_next      = cnt_inc;
        if (cnt_inc == KEY_BYTES) finish = 1'b1;
      end
      PH_DATA: begin
        res_valid      = 1'b1;
        res.kind       = KIND_PAYLOAD;
        res.data_byte  = mask_flag ? (in_byte ^ key_byte) : in_byte;
        res.last       = (remaining == {{(LEN_W-1){1'b0}}, 1'b1});
        remaining_next = remaining - {{(LEN_W-1){1'b0}}, 1'b1};
        key_idx_next   = key_idx + 2'd1;
        if (res.last) phase_next = PH_FIRST;
      end
      default: phase_next = PH_FIRST;
    endcase

    if (finish) begin
      res_valid      = 1'b1;
      res.last       = (frame_length_next == '0);
      remaining_next = frame_length_next;
      key_idx_next   = 2'd0;
      cnt_next       = 3'd0;
      phase_next     = res.last ? PH_FIRST : PH_DATA;
    end

    res.fin            = header_bits[7];
    res.reserved_bits  = header_bits[6:4];
    res.opcode         = header_bits[3:0];
    res.masked         = mask_flag_next;
    res.payload_length = frame_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      cnt          <= 3'd0;
      header_bits  <= 8'h00;
      mask_flag    <= 1'b0;
      short_length <= 7'd0;
      frame_length <= '0;
      remaining    <= '0;
      key_idx      <= 2'd0;
      key_word     <= 32'h0;
    end else if (accept) begin
      phase        <= phase_next;
      cnt          <= cnt_next;
      header_bits  <= header_bits_next;
      mask_flag    <= mask_flag_next;
      short_length <= short_length_next;
      frame_length <= frame_length_next;
      remaining    <= remaining_next;
      key_idx      <= key_idx_next;
      key_word     <= key_word_next;
    end
  end

  `ASSERT_IMPLIES(a_data_has_bytes_left, clk, rst, phase == PH_DATA, remaining != '0)
  `ASSERT_NEXT(a_last_byte_ends_frame, clk, rst,
    accept && phase == PH_DATA && remaining == {{(LEN_W-1){1'b0}}, 1'b1}, phase == PH_FIRST)
  `ASSERT_IMPLIES(a_key_count_bound, clk, rst, phase == PH_KEY, cnt < KEY_BYTES)

endmodule

// ===== rtl/wsd_out_stage.sv =====
`include "assert_macros.svh"

module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    space,
  input  logic    pop_ready,
  output logic    out_valid,
  output result_t out_res
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_res;
  result_t skid_res;
  logic    pop;

  assign pop       = main_valid & pop_ready;
  assign space     = ~skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push && (!main_valid || pop)) begin
      main_valid <= 1'b1;
    end else if (push) begin
      skid_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) main_res <= skid_res;
    end else if (push && (!main_valid || pop)) begin
      main_res <= push_res;
    end else if (push) begin
      skid_res <= push_res;
    end
  end

  `ASSERT_IMPLIES(a_skid_behind_main, clk, rst, skid_valid, main_valid)
  `ASSERT_NEXT(a_skid_held_on_stall, clk, rst, skid_valid && !pop, skid_valid && main_valid)
  `ASSERT_IMPLIES(a_no_push_when_full, clk, rst, skid_valid, !push)

endmodule

// ===== rtl/websocket_frame_deframer_unit.sv =====
// WebSocket frame deframer (RFC 6455 base framing). Raw frame bytes enter one
// per request on the s_ side; the unit parses the first header byte (FIN,
// RSV1..RSV3, opcode), the mask/length byte, a 16- or 64-bit big-endian
// extended length and an optional 4-byte masking key. The byte that completes
// the header yields one header request (tuser = 0, tdata byte zero), with
// tlast set when the payload is empty; every payload byte then yields one
// request (tuser = 1) carrying the byte unmasked with key byte (offset mod 4),
// tlast on the final byte. Other header bytes yield nothing. All requests carry
// the current frame's header fields. Throughput is one byte per clock: the
// parse step is a single registered pass of state update per byte, and a
// two-entry output stage lets a new byte be taken while a result waits, so
// s_tready only drops once both output entries are full. Every result is
// registered in the output stage before m_. Extended lengths are taken as
// given, including non-minimal encodings and lengths with the top bit set.

module websocket_frame_deframer_unit
  import wsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] in_byte
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] data_byte, [8] fin,
                                           // [11:9] reserved_bits, [15:12] opcode,
                                           // [16] masked, [80:17] payload_length,
                                           // [87:81] zero
  output logic                  m_tuser,   // [0] kind: 0 header, 1 payload byte
  output logic                  m_tlast    // final request of the frame
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // a byte is only taken while the output stage has room for its result
  assign accept = s_tvalid & s_tready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept & res_valid),
    .push_res  (res),
    .space     (s_tready),
    .pop_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res)
  );

  assign m_tdata = {7'd0, out_res.payload_length, out_res.masked, out_res.opcode,
                    out_res.reserved_bits, out_res.fin, out_res.data_byte};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule
